>>> sv/tcpq_pkg.sv
// shared types and codes for the two-class priority queue
`default_nettype none

package tcpq_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // operation codes
  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [VALUE_W-1:0] THRESH_RESET = 32'sd60;

  // one queue slot as seen by its neighbors
  typedef struct packed {
    logic                      valid;
    logic                      high;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                      enq;
    logic                      deq;
    logic                      clr;
    logic                      new_high;
    logic signed [VALUE_W-1:0] new_value;
  } ctrl_t;

endpackage

`default_nettype wire

>>> sv/tcpq_cell.sv
// one slot of the sorted queue chain
`default_nettype none

module tcpq_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tcpq_pkg::ctrl_t  ctrl_i,
  input  wire tcpq_pkg::entry_t left_i,
  input  wire logic            left_stay_i,
  input  wire tcpq_pkg::entry_t right_i,
  output tcpq_pkg::entry_t     q_o,
  output logic                 stay_o
);
  import tcpq_pkg::*;

  logic                      valid_q, valid_d;
  logic                      high_q, high_d;
  logic signed [VALUE_W-1:0] value_q, value_d;

  // slot keeps its place on insert when it holds a value ahead of the new one
  assign stay_o = valid_q & (high_q | ~ctrl_i.new_high);

  // next slot contents
  always_comb begin
    valid_d = valid_q;
    high_d  = high_q;
    value_d = value_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.deq) begin
      valid_d = right_i.valid;
      high_d  = right_i.high;
      value_d = right_i.value;
    end else if (ctrl_i.enq && !stay_o) begin
      if (left_stay_i) begin
        valid_d = 1'b1;
        high_d  = ctrl_i.new_high;
        value_d = ctrl_i.new_value;
      end else begin
        valid_d = left_i.valid;
        high_d  = left_i.high;
        value_d = left_i.value;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // slot payload
  always_ff @(posedge clk_i) begin
    high_q  <= high_d;
    value_q <= value_d;
  end

  assign q_o.valid = valid_q;
  assign q_o.high  = high_q;
  assign q_o.value = value_q;

endmodule

`default_nettype wire

>>> sv/two_class_priority_queue.sv
// top level of the two-class strict-priority queue
// Usage: one beat on the input channel (operation_i, item_value_i) carries an
// enqueue, a dequeue or a clear; every input beat gives exactly one result beat
// (status_o, removed_value_o, entry_count_o, is_empty_o) on the output channel.
// Values at or above the threshold on the config channel join the high class,
// behind earlier high values and ahead of all low values; the rest join the tail.
// The queue is a row of CAPACITY cells, head in cell 0; on each operation every
// cell loads from itself, its left or its right neighbor, so one item is handled
// per cycle while the receiver takes results; each result beat appears in the
// cycle after its input beat is taken.
// The result sits in an output register; a new input beat is taken whenever that
// register is empty or is being read in the same cycle. When the receiver stalls,
// the result holds and in_ready_o drops until it is taken.
// Config writes are accepted every cycle and should come only while idle.
// Reset empties the queue, drops any pending result and sets the threshold to 60.
`default_nettype none

module two_class_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic signed [tcpq_pkg::VALUE_W-1:0]   cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic        [tcpq_pkg::OP_W-1:0]      operation_i,
  input  wire logic signed [tcpq_pkg::VALUE_W-1:0]   item_value_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic             [tcpq_pkg::STAT_W-1:0]    status_o,
  output logic signed      [tcpq_pkg::VALUE_W-1:0]   removed_value_o,
  output logic             [tcpq_pkg::COUNT_W-1:0]   entry_count_o,
  output logic                                       is_empty_o
);
  import tcpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic signed [VALUE_W-1:0] thresh_q;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      out_valid_q;
  logic [STAT_W-1:0]         status_q, status_d;
  logic signed [VALUE_W-1:0] removed_q, removed_d;
  logic [COUNT_W-1:0]        ecount_q;
  logic                      empty_q;
  logic                      accept;
  logic                      full, empty;
  logic [CNT_W+COUNT_W-1:0]  count_wide;
  ctrl_t                     ctrl;
  entry_t                    cell_q [CAPACITY];
  logic                      stay   [CAPACITY];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign accept      = in_valid_i & in_ready_o;
  assign full        = (count_q == CAP_CNT);
  assign empty       = (count_q == '0);

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_valid_i) begin
      thresh_q <= cfg_data_i;
    end
  end

  // command to the cell row, status and count
  always_comb begin
    ctrl.enq       = 1'b0;
    ctrl.deq       = 1'b0;
    ctrl.clr       = 1'b0;
    ctrl.new_high  = (item_value_i >= thresh_q);
    ctrl.new_value = item_value_i;
    status_d       = ST_OK;
    removed_d      = '0;
    count_d        = count_q;
    if (accept) begin
      unique case (operation_i)
        OP_ENQ: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.enq = 1'b1;
            count_d  = count_q + 1'b1;
          end
        end
        OP_DEQ: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.deq  = 1'b1;
            removed_d = cell_q[0].value;
            count_d   = count_q - 1'b1;
          end
        end
        OP_CLR: begin
          ctrl.clr = 1'b1;
          count_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // row of cells, head at cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left, right;
    logic   left_stay;
    if (i == 0) begin : g_first
      assign left      = '0;
      assign left_stay = 1'b1;
    end else begin : g_mid
      assign left      = cell_q[i-1];
      assign left_stay = stay[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_q[i+1];
    end
    tcpq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .left_i      (left),
      .left_stay_i (left_stay),
      .right_i     (right),
      .q_o         (cell_q[i]),
      .stay_o      (stay[i])
    );
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // count reported in its low bits
  assign count_wide = {{COUNT_W{1'b0}}, count_d};

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      ecount_q  <= count_wide[COUNT_W-1:0];
      empty_q   <= (count_d == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign entry_count_o   = ecount_q;
  assign is_empty_o      = empty_q;

endmodule

`default_nettype wire

>>> dv/two_class_priority_queue_tb.sv
// self-checking testbench for the two-class strict-priority queue
module two_class_priority_queue_tb;
  import tcpq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_PER_PHASE = 86;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_PRINTED = 40;

  // the one code the package leaves unnamed
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
  } queue_op_t;

  typedef struct packed {
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] removed;
    logic [COUNT_W-1:0]        count;
    logic                      empty;
  } queue_result_t;

  // block ports
  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic signed [VALUE_W-1:0] cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [OP_W-1:0]           operation_i = OP_ENQ;
  logic signed [VALUE_W-1:0] item_value_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [STAT_W-1:0]         status_o;
  logic signed [VALUE_W-1:0] removed_value_o;
  logic [COUNT_W-1:0]        entry_count_o;
  logic                      is_empty_o;

  // predicted queue contents and threshold
  logic signed [VALUE_W-1:0] high_vals[$];
  logic signed [VALUE_W-1:0] low_vals[$];
  logic signed [VALUE_W-1:0] model_threshold = THRESH_RESET;

  queue_op_t     pending_ops[$];
  queue_result_t expected_results[$];
  queue_op_t     held_op;

  int unsigned issued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // sender burst and receiver stall state
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned pattern_phase = 0;

  two_class_priority_queue #(
    .CAPACITY (QUEUE_DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .item_value_i    (item_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .entry_count_o   (entry_count_o),
    .is_empty_o      (is_empty_o)
  );

  always #2 clk_i = ~clk_i;

  // apply one operation to the predicted queue and return its result
  function automatic queue_result_t apply_queue_op(input queue_op_t op_item);
    queue_result_t res;
    int unsigned   total;
    res.status  = ST_OK;
    res.removed = '0;
    case (op_item.op)
      OP_ENQ: begin
        if (high_vals.size() + low_vals.size() >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else if ($signed(op_item.value) >= $signed(model_threshold)) begin
          high_vals.push_back(op_item.value);
        end else begin
          low_vals.push_back(op_item.value);
        end
      end
      OP_DEQ: begin
        if (high_vals.size() > 0) begin
          res.removed = high_vals.pop_front();
        end else if (low_vals.size() > 0) begin
          res.removed = low_vals.pop_front();
        end else begin
          res.status = ST_EMPTY;
        end
      end
      OP_CLR: begin
        high_vals.delete();
        low_vals.delete();
      end
      default: begin
      end
    endcase
    total     = high_vals.size() + low_vals.size();
    res.count = COUNT_W'(total);
    res.empty = (total == 0);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTED) begin
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    end
    error_count++;
  endtask

  task automatic queue_op(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value);
    queue_op_t op_item;
    op_item.op    = op;
    op_item.value = value;
    pending_ops.push_back(op_item);
    issued_count++;
  endtask

  // values near the threshold, small values, or any 32-bit pattern
  function automatic logic signed [VALUE_W-1:0] pick_value();
    int     sel;
    longint near_val;
    sel = $urandom_range(0, 5);
    if (sel < 2) begin
      near_val = longint'($signed(model_threshold)) + longint'($urandom_range(0, 4)) - 2;
      if (near_val > longint'(VALUE_MAX)) near_val = longint'(VALUE_MAX);
      if (near_val < longint'(VALUE_MIN)) near_val = longint'(VALUE_MIN);
      return VALUE_W'(near_val);
    end else if (sel < 4) begin
      return VALUE_W'(int'($urandom_range(0, 200)) - 100);
    end else begin
      return $urandom;
    end
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int unsigned enq_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_CLR;
    if (r < 5) return OP_UNUSED;
    if (r < 5 + enq_pct) return OP_ENQ;
    return OP_DEQ;
  endfunction

  // config beat, only sent while the queue has no work in flight
  task automatic write_threshold(input logic signed [VALUE_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i     <= 1'b0;
    model_threshold = value;
  endtask

  task automatic wait_idle();
    while (!(accepted_count == issued_count && expected_results.size() == 0)) begin
      @(posedge clk_i);
    end
  endtask

  // input driver: bursts of beats separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      operation_i  <= OP_ENQ;
      item_value_i <= '0;
    end else if (in_valid_i && !in_ready_o) begin
      // hold the beat until it is taken
    end else begin
      if (in_valid_i) begin
        expected_results.push_back(apply_queue_op(held_op));
        accepted_count++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        held_op = pending_ops.pop_front();
        in_valid_i   <= 1'b1;
        operation_i  <= held_op.op;
        item_value_i <= held_op.value;
        if (burst_left <= 1) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(40, 80);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", {30'b0, status_o}, '0);
        end else begin
          queue_result_t want;
          want = expected_results.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", {30'b0, status_o}, {30'b0, want.status});
          if (removed_value_o !== want.removed)
            report_mismatch("removed_value", removed_value_o, want.removed);
          if (entry_count_o !== want.count)
            report_mismatch("entry_count", {27'b0, entry_count_o}, {27'b0, want.count});
          if (is_empty_o !== want.empty)
            report_mismatch("is_empty", {31'b0, is_empty_o}, {31'b0, want.empty});
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 128);
      end else begin
        mode_left--;
      end
      pattern_phase++;
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        2: out_ready_i <= (pattern_phase % 4 == 0);
        default: out_ready_i <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("two_class_priority_queue regression: fail");
    $finish;
  end

  // reset, directed beats, then random phases over several thresholds
  initial begin
    logic signed [VALUE_W-1:0] phase_thresholds[6];
    phase_thresholds[0] = VALUE_MIN;
    phase_thresholds[1] = VALUE_MAX;
    phase_thresholds[2] = 32'sd0;
    phase_thresholds[3] = -32'sd1;
    phase_thresholds[4] = $urandom;
    phase_thresholds[5] = THRESH_RESET;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty dequeue, both sides of the default threshold, extremes, unused code
    queue_op(OP_DEQ, 32'sd5);
    queue_op(OP_ENQ, 32'sd59);
    queue_op(OP_ENQ, 32'sd60);
    queue_op(OP_ENQ, VALUE_MIN);
    queue_op(OP_ENQ, VALUE_MAX);
    queue_op(OP_UNUSED, 32'sh5a5a_a5a5);
    queue_op(OP_DEQ, '0);
    queue_op(OP_CLR, 32'sh1234_5678);
    // fill to capacity, then one refused enqueue
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      queue_op(OP_ENQ, (i % 2 == 0) ? 32'(i * 9 + 20) : $urandom);
    end
    queue_op(OP_ENQ, 32'sd100);
    wait_idle();

    // random phases; the queue keeps its contents across threshold changes
    for (int ph = 0; ph <= 6; ph++) begin
      if (ph > 0) write_threshold(phase_thresholds[ph - 1]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        queue_op(pick_op((n < RANDOM_PER_PHASE / 2) ? 75 : 25), pick_value());
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      report_mismatch("results still pending at end", expected_results.size(), '0);
    end
    if (error_count == 0) begin
      $display("two_class_priority_queue regression: pass");
    end else begin
      $display("two_class_priority_queue regression: fail");
    end
    $finish;
  end

endmodule
